// ===== sv/sacl_pkg.sv =====
// Shared types, sizes and register codes for the set-associative cache model.
`timescale 1ns / 1ps

package sacl_pkg;

   localparam int MAX_WAYS   = 8;
   localparam int MAX_SETS   = 1024;
   localparam int WAY_W      = $clog2(MAX_WAYS);
   localparam int RANK_W     = WAY_W;
   localparam int SET_W      = $clog2(MAX_SETS);
   localparam int INDEX_MAX  = $clog2(MAX_SETS + 1) - 1;
   localparam int ENTRIES    = MAX_SETS * MAX_WAYS;
   localparam int ENTRY_W    = SET_W + WAY_W;
   localparam int TAG_W      = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY = 4'd3;

   localparam logic [3:0] WAYS_RESET    = 4'd2;
   localparam logic [3:0] OFFSET_RESET  = 4'd5;
   localparam logic [3:0] INDEX_RESET   = 4'd10;
   localparam logic [9:0] PENALTY_RESET = 10'd30;

   // extra cycles when the victim is dirty
   localparam logic [16:0] DIRTY_EXTRA = 17'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] address;
      logic [15:0] instr_count;
   } sacl_req_type;

   typedef struct packed {
      logic        hit;
      logic        dirty_evict;
      logic [2:0]  way_used;
      logic [16:0] access_cycles;
      logic [31:0] total_cycles;
      logic [31:0] total_instructions;
      logic [31:0] access_total;
      logic [31:0] load_hit_total;
      logic [31:0] load_miss_total;
      logic [31:0] store_hit_total;
      logic [31:0] store_miss_total;
      logic [31:0] dirty_evict_total;
   } sacl_rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             valid;
      logic             dirty;
   } sacl_entry_type;

   typedef logic [MAX_WAYS-1:0][RANK_W-1:0] sacl_rank_row_type;

   typedef struct packed {
      sacl_entry_type    entry;
      logic [TAG_W-1:0]  req_tag;
      logic [RANK_W-1:0] rank;
      logic [RANK_W-1:0] best_rank;
      logic              first;
   } sacl_cmp_in_type;

   typedef struct packed {
      logic match;
      logic invalid;
      logic better;
   } sacl_cmp_out_type;

   typedef struct packed {
      logic        fire;
      logic        store;
      logic        hit;
      logic        dirty_evict;
      logic [16:0] access_cycles;
      logic [15:0] instr_count;
   } sacl_event_type;

   typedef struct packed {
      logic [31:0] total_cycles;
      logic [31:0] total_instructions;
      logic [31:0] access_total;
      logic [31:0] load_hit_total;
      logic [31:0] load_miss_total;
      logic [31:0] store_hit_total;
      logic [31:0] store_miss_total;
      logic [31:0] dirty_evict_total;
   } sacl_totals_type;

endpackage

// ===== sv/set_assoc_cache_lru_writeback.sv =====
// Top level: set-associative LRU write-back cache model with way-serial lookup.
// channel | ports                               | beat taken when
// --------+-------------------------------------+------------------------------
// request | start, busy, req_data               | start && !busy
// result  | rsp_valid, rsp_data                 | every cycle rsp_valid is high
// config  | csr_valid, csr_ready, csr_index/data| csr_valid && csr_ready
//
// An access runs S_LOOK, k = 1..ways_in_use ways examined by the shared
// compare unit (stops on a hit), then S_UPD, which registers the result
// strobe; the next request is taken in the result cycle. Reset starts a sweep
// of all 8192 tag entries (one tag entry per cycle, one rank row every eighth)
// with busy high; writing ways_in_use while idle or sweeping re-runs it to
// re-seed ranks, leaving tags unless the reset sweep runs. The receiver cannot
// stall: each result is up for one cycle only. csr_ready is always high.
`timescale 1ns / 1ps

module set_assoc_cache_lru_writeback (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  sacl_pkg::sacl_req_type               req_data,
   // result
   output logic                                 rsp_valid,
   output sacl_pkg::sacl_rsp_type               rsp_data,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int NW_W = sacl_pkg::WAY_W + 1;   // holds a way count 1..MAX_WAYS

   // sequencer states
   localparam logic [1:0] S_CLEAR = 2'd0;   // reset / re-seed sweep
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_LOOK  = 2'd2;   // one way per cycle
   localparam logic [1:0] S_UPD   = 2'd3;   // write back entry and rank row

   localparam logic [sacl_pkg::ENTRY_W-1:0] CLR_LAST =
      sacl_pkg::ENTRY_W'(sacl_pkg::ENTRIES - 1);

   // configuration registers
   logic [3:0] ways_ff,    ways_in;
   logic [3:0] offset_ff,  offset_in;
   logic [3:0] index_ff,   index_in;
   logic [9:0] penalty_ff, penalty_in;
   logic       reseed;

   // sequencer
   logic [1:0]                   state_ff, state_in;
   logic [sacl_pkg::ENTRY_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                         clr_tags_ff, clr_tags_in;

   // latched access
   logic [sacl_pkg::SET_W-1:0]  set_ff, set_in;
   logic [sacl_pkg::TAG_W-1:0]  tag_ff, tag_in;
   logic                        store_ff, store_in;
   logic [15:0]                 icount_ff, icount_in;

   // way scan
   logic [sacl_pkg::WAY_W-1:0]  way_cnt_ff, way_cnt_in;
   logic                        hit_ff, hit_in;
   logic [sacl_pkg::WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic                        hit_dirty_ff, hit_dirty_in;
   logic                        inv_found_ff, inv_found_in;
   logic [sacl_pkg::WAY_W-1:0]  inv_way_ff, inv_way_in;
   logic [sacl_pkg::WAY_W-1:0]  best_way_ff, best_way_in;
   logic [sacl_pkg::RANK_W-1:0] best_rank_ff, best_rank_in;
   logic                        best_dirty_ff, best_dirty_in;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_hit_ff, rsp_hit_in;
   logic        rsp_dev_ff, rsp_dev_in;
   logic [2:0]  rsp_way_ff, rsp_way_in;
   logic [16:0] rsp_acc_ff, rsp_acc_in;

   // address split
   logic [NW_W-1:0]            n_ways;
   logic [3:0]                 ib;
   logic [4:0]                 tag_shift;
   logic [31:0]                set_full;
   logic [sacl_pkg::SET_W-1:0] set_calc;
   logic [sacl_pkg::TAG_W-1:0] tag_calc;

   // memories
   logic                            tag_wr_en, tag_rd_en;
   logic [sacl_pkg::ENTRY_W-1:0]    tag_wr_addr, tag_rd_addr;
   sacl_pkg::sacl_entry_type        tag_wr_data, tag_rd_data;
   logic                            rank_wr_en, rank_rd_en;
   logic [sacl_pkg::SET_W-1:0]      rank_wr_addr, rank_rd_addr;
   sacl_pkg::sacl_rank_row_type     rank_wr_data, rank_rd_data;
   sacl_pkg::sacl_rank_row_type     seed_row, touch_row;

   // update-cycle decisions
   logic [sacl_pkg::WAY_W-1:0]  way_sel;
   logic                        dev;
   logic [sacl_pkg::RANK_W-1:0] sel_rank;

   sacl_pkg::sacl_cmp_in_type   cmp_in;
   sacl_pkg::sacl_cmp_out_type  cmp_out;
   sacl_pkg::sacl_event_type    ev;
   sacl_pkg::sacl_totals_type   totals;

   // ---------------------------------------------------------------
   // Config port: always ready; ways write in idle or sweep triggers a re-seed
   // ---------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      ways_in    = ways_ff;
      offset_in  = offset_ff;
      index_in   = index_ff;
      penalty_in = penalty_ff;
      reseed     = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            sacl_pkg::CSR_WAYS: begin
               ways_in = csr_data[3:0];
               reseed  = 1'b1;
            end
            sacl_pkg::CSR_OFFSET:  offset_in  = csr_data[3:0];
            sacl_pkg::CSR_INDEX:   index_in   = csr_data[3:0];
            sacl_pkg::CSR_PENALTY: penalty_in = csr_data[9:0];
            default: ;   // unknown index: dropped
         endcase
      end
   end

   // effective way count: 0 acts as 1, clamp at MAX_WAYS
   always_comb begin
      if (ways_ff == 4'd0) begin
         n_ways = NW_W'(1);
      end else if (32'(ways_ff) > sacl_pkg::MAX_WAYS) begin
         n_ways = NW_W'(sacl_pkg::MAX_WAYS);
      end else begin
         n_ways = NW_W'(ways_ff);
      end
   end

   // ---------------------------------------------------------------
   // Address split. offset + clamped index stays below 32, so the tag
   // shift never runs off the word.
   // ---------------------------------------------------------------
   always_comb begin
      ib        = (32'(index_ff) > sacl_pkg::INDEX_MAX) ? 4'(sacl_pkg::INDEX_MAX) : index_ff;
      tag_shift = {1'b0, offset_ff} + {1'b0, ib};
      set_full  = (req_data.address >> offset_ff) & ((32'd1 << ib) - 32'd1);
      set_calc  = set_full[sacl_pkg::SET_W-1:0];
      tag_calc  = req_data.address >> tag_shift;
   end

   // ---------------------------------------------------------------
   // Rank rows: seed pattern, and the LRU touch of the chosen way
   // ---------------------------------------------------------------
   always_comb begin
      for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
         if (NW_W'(w) < n_ways) begin
            seed_row[w] = sacl_pkg::RANK_W'(n_ways - NW_W'(1) - NW_W'(w));
         end else begin
            seed_row[w] = '0;
         end
      end
   end

   always_comb begin
      if (hit_ff) begin
         way_sel = hit_way_ff;
      end else if (inv_found_ff) begin
         way_sel = inv_way_ff;
      end else begin
         way_sel = best_way_ff;
      end
      dev      = !hit_ff && !inv_found_ff && best_dirty_ff;
      sel_rank = rank_rd_data[way_sel];
      touch_row = rank_rd_data;
      for (int w = 0; w < sacl_pkg::MAX_WAYS; w++) begin
         if ((NW_W'(w) < n_ways) && (rank_rd_data[w] < sel_rank)) begin
            touch_row[w] = rank_rd_data[w] + sacl_pkg::RANK_W'(1);
         end
      end
      touch_row[way_sel] = '0;
   end

   // shared compare unit, fed with the way whose entry just came out of RAM
   always_comb begin
      cmp_in.entry     = tag_rd_data;
      cmp_in.req_tag   = tag_ff;
      cmp_in.rank      = rank_rd_data[way_cnt_ff];
      cmp_in.best_rank = best_rank_ff;
      cmp_in.first     = (way_cnt_ff == '0);
   end

   sacl_way_cmp u_way_cmp (
      .cmp_in  (cmp_in),
      .cmp_out (cmp_out)
   );

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_tags_in   = clr_tags_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      store_in      = store_ff;
      icount_in     = icount_ff;
      way_cnt_in    = way_cnt_ff;
      hit_in        = hit_ff;
      hit_way_in    = hit_way_ff;
      hit_dirty_in  = hit_dirty_ff;
      inv_found_in  = inv_found_ff;
      inv_way_in    = inv_way_ff;
      best_way_in   = best_way_ff;
      best_rank_in  = best_rank_ff;
      best_dirty_in = best_dirty_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_dev_in    = rsp_dev_ff;
      rsp_way_in    = rsp_way_ff;
      rsp_acc_in    = rsp_acc_ff;

      tag_wr_en    = 1'b0;
      tag_wr_addr  = {set_ff, way_sel};
      tag_wr_data  = '0;
      tag_rd_en    = 1'b0;
      tag_rd_addr  = {set_calc, sacl_pkg::WAY_W'(0)};
      rank_wr_en   = 1'b0;
      rank_wr_addr = set_ff;
      rank_wr_data = touch_row;
      rank_rd_en   = 1'b0;
      rank_rd_addr = set_calc;

      ev.fire          = 1'b0;
      ev.store         = store_ff;
      ev.hit           = hit_ff;
      ev.dirty_evict   = dev;
      ev.instr_count   = icount_ff;
      ev.access_cycles = 17'(icount_ff);
      if (!hit_ff) begin
         ev.access_cycles = 17'(icount_ff) + 17'(penalty_ff) +
                            (dev ? sacl_pkg::DIRTY_EXTRA : 17'd0);
      end

      unique case (state_ff)
         S_CLEAR: begin
            // tags only on the reset sweep; ranks on every sweep
            tag_wr_en    = clr_tags_ff;
            tag_wr_addr  = clr_cnt_ff;
            tag_wr_data  = '0;
            rank_wr_en   = (clr_cnt_ff[sacl_pkg::WAY_W-1:0] == '0);
            rank_wr_addr = clr_cnt_ff[sacl_pkg::ENTRY_W-1:sacl_pkg::WAY_W];
            rank_wr_data = seed_row;
            if (clr_cnt_ff == CLR_LAST) begin
               state_in    = S_IDLE;
               clr_tags_in = 1'b0;
            end else begin
               clr_cnt_in = clr_cnt_ff + sacl_pkg::ENTRY_W'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               set_in       = set_calc;
               tag_in       = tag_calc;
               store_in     = req_data.action;
               icount_in    = req_data.instr_count;
               tag_rd_en    = 1'b1;
               rank_rd_en   = 1'b1;
               way_cnt_in   = '0;
               hit_in       = 1'b0;
               inv_found_in = 1'b0;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            if (cmp_out.match) begin
               hit_in       = 1'b1;
               hit_way_in   = way_cnt_ff;
               hit_dirty_in = tag_rd_data.dirty;
               state_in     = S_UPD;
            end else begin
               if (cmp_out.invalid && !inv_found_ff) begin
                  inv_found_in = 1'b1;
                  inv_way_in   = way_cnt_ff;
               end
               if (cmp_out.better) begin
                  best_way_in   = way_cnt_ff;
                  best_rank_in  = cmp_in.rank;
                  best_dirty_in = tag_rd_data.dirty;
               end
               if ({1'b0, way_cnt_ff} == (n_ways - NW_W'(1))) begin
                  state_in = S_UPD;
               end else begin
                  way_cnt_in  = way_cnt_ff + sacl_pkg::WAY_W'(1);
                  tag_rd_en   = 1'b1;
                  tag_rd_addr = {set_ff, way_cnt_ff + sacl_pkg::WAY_W'(1)};
               end
            end
         end
         S_UPD: begin
            tag_wr_en         = 1'b1;
            tag_wr_data.tag   = tag_ff;
            tag_wr_data.valid = 1'b1;
            tag_wr_data.dirty = hit_ff ? (hit_dirty_ff | store_ff) : store_ff;
            rank_wr_en        = 1'b1;
            ev.fire           = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_hit_in        = hit_ff;
            rsp_dev_in        = dev;
            rsp_way_in        = 3'(way_sel);
            rsp_acc_in        = ev.access_cycles;
            state_in          = S_IDLE;
         end
      endcase

      // in idle or sweep a way write restarts the sweep, keeping tag-clear mode
      if (reseed && ((state_ff == S_IDLE) || (state_ff == S_CLEAR))) begin
         state_in   = S_CLEAR;
         clr_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff      <= sacl_pkg::WAYS_RESET;
         offset_ff    <= sacl_pkg::OFFSET_RESET;
         index_ff     <= sacl_pkg::INDEX_RESET;
         penalty_ff   <= sacl_pkg::PENALTY_RESET;
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_tags_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         ways_ff      <= ways_in;
         offset_ff    <= offset_in;
         index_ff     <= index_in;
         penalty_ff   <= penalty_in;
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_tags_ff  <= clr_tags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan registers: no reset needed
   always_ff @(posedge clock) begin
      set_ff        <= set_in;
      tag_ff        <= tag_in;
      store_ff      <= store_in;
      icount_ff     <= icount_in;
      way_cnt_ff    <= way_cnt_in;
      hit_ff        <= hit_in;
      hit_way_ff    <= hit_way_in;
      hit_dirty_ff  <= hit_dirty_in;
      inv_found_ff  <= inv_found_in;
      inv_way_ff    <= inv_way_in;
      best_way_ff   <= best_way_in;
      best_rank_ff  <= best_rank_in;
      best_dirty_ff <= best_dirty_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_dev_ff    <= rsp_dev_in;
      rsp_way_ff    <= rsp_way_in;
      rsp_acc_ff    <= rsp_acc_in;
   end

   // tag/valid/dirty per entry, addressed {set, way}
   sacl_ram #(
      .WIDTH ($bits(sacl_pkg::sacl_entry_type)),
      .DEPTH (sacl_pkg::ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   // one row of LRU ranks per set
   sacl_ram #(
      .WIDTH ($bits(sacl_pkg::sacl_rank_row_type)),
      .DEPTH (sacl_pkg::MAX_SETS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (rank_wr_addr),
      .wr_data (rank_wr_data),
      .rd_en   (rank_rd_en),
      .rd_addr (rank_rd_addr),
      .rd_data (rank_rd_data)
   );

   sacl_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .ev     (ev),
      .totals (totals)
   );

   // ---------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.hit                = rsp_hit_ff;
      rsp_data.dirty_evict        = rsp_dev_ff;
      rsp_data.way_used           = rsp_way_ff;
      rsp_data.access_cycles      = rsp_acc_ff;
      rsp_data.total_cycles       = totals.total_cycles;
      rsp_data.total_instructions = totals.total_instructions;
      rsp_data.access_total       = totals.access_total;
      rsp_data.load_hit_total     = totals.load_hit_total;
      rsp_data.load_miss_total    = totals.load_miss_total;
      rsp_data.store_hit_total    = totals.store_hit_total;
      rsp_data.store_miss_total   = totals.store_miss_total;
      rsp_data.dirty_evict_total  = totals.dirty_evict_total;
   end

`ifndef ASSERT_OFF
   // result strobes never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not make the block busy");

   a_from_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_UPD))
      else $error("result strobe without an update cycle");

   a_hit_no_penalty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |->
         (!rsp_data.dirty_evict && (rsp_data.access_cycles == 17'(icount_ff))))
      else $error("hit carries an eviction or a penalty");
`endif

endmodule

// ===== sv/sacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sacl_way_cmp.sv =====
// Shared per-way unit: tag match, invalid check and LRU rank compare.
`timescale 1ns / 1ps

module sacl_way_cmp (
   input  sacl_pkg::sacl_cmp_in_type  cmp_in,
   output sacl_pkg::sacl_cmp_out_type cmp_out
);

   always_comb begin
      cmp_out.match   = cmp_in.entry.valid && (cmp_in.entry.tag == cmp_in.req_tag);
      cmp_out.invalid = !cmp_in.entry.valid;
      // strict greater keeps the lowest way on a tie
      cmp_out.better  = cmp_in.first || (cmp_in.rank > cmp_in.best_rank);
   end

endmodule

// ===== sv/sacl_stats.sv =====
// Saturating running totals and event counters.
`timescale 1ns / 1ps

module sacl_stats (
   input  logic                      clock,
   input  logic                      reset,
   input  sacl_pkg::sacl_event_type  ev,
   output sacl_pkg::sacl_totals_type totals
);

   sacl_pkg::sacl_totals_type tot_ff;
   sacl_pkg::sacl_totals_type tot_in;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   always_comb begin
      tot_in = tot_ff;
      if (ev.fire) begin
         tot_in.total_cycles       = sat_add(tot_ff.total_cycles, 32'(ev.access_cycles));
         tot_in.total_instructions = sat_add(tot_ff.total_instructions, 32'(ev.instr_count));
         tot_in.access_total       = sat_add(tot_ff.access_total, 32'd1);
         if (ev.hit && !ev.store) begin
            tot_in.load_hit_total = sat_add(tot_ff.load_hit_total, 32'd1);
         end
         if (!ev.hit && !ev.store) begin
            tot_in.load_miss_total = sat_add(tot_ff.load_miss_total, 32'd1);
         end
         if (ev.hit && ev.store) begin
            tot_in.store_hit_total = sat_add(tot_ff.store_hit_total, 32'd1);
         end
         if (!ev.hit && ev.store) begin
            tot_in.store_miss_total = sat_add(tot_ff.store_miss_total, 32'd1);
         end
         if (ev.dirty_evict) begin
            tot_in.dirty_evict_total = sat_add(tot_ff.dirty_evict_total, 32'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff <= '0;
      end else begin
         tot_ff <= tot_in;
      end
   end

   assign totals = tot_ff;

endmodule
